FILE: src/framed_reply_receiver_with_sum_check_core_macros.svh
// ----------------------------------------------------------------------------
// framed reply receiver assertion macros
// clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef FRAMED_REPLY_RECEIVER_WITH_SUM_CHECK_CORE_MACROS_SVH
`define FRAMED_REPLY_RECEIVER_WITH_SUM_CHECK_CORE_MACROS_SVH

// condition holds at every edge
`define FRSC_ASSERT_HOLD(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// consequent holds in the same cycle
`define FRSC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define FRSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/frsc_pkg.sv
// ----------------------------------------------------------------------------
// frsc_pkg
// codes, widths and the speed scaling for the framed reply receiver
// ----------------------------------------------------------------------------
package frsc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned SPEED_W = 4;
    localparam int unsigned STAT_W  = 3;
    localparam int unsigned OUT_W   = 88;

    localparam logic [BYTE_W-1:0] START_MARK    = 8'hFF;
    localparam logic [BYTE_W-1:0] CMD_SERVO_ONE = 8'h17;
    localparam logic [BYTE_W-1:0] CMD_SPEED     = 8'h57;
    localparam logic [BYTE_W-1:0] CMD_STEPS     = 8'h97;
    localparam logic [BYTE_W-1:0] CMD_TURN      = 8'h77;
    localparam logic [BYTE_W-1:0] CMD_SERVO_TWO = 8'hB7;
    localparam logic [BYTE_W-1:0] CMD_RANGE     = 8'h27;
    localparam logic [BYTE_W-1:0] CMD_TARGET_X  = 8'h47;
    localparam logic [BYTE_W-1:0] CMD_TARGET_Y  = 8'h67;

    localparam logic [SPEED_W-1:0] SPEED_TOP   = 4'd14;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 4'd5;
    localparam logic [WORD_W-1:0]  WORD_FULL   = 16'hFFFF;

    typedef enum logic [STAT_W-1:0] {
        ST_BUSY    = 3'd0,
        ST_APPLIED = 3'd1,
        ST_BAD_SUM = 3'd2,
        ST_STRAY   = 3'd3,
        ST_FOREIGN = 3'd4
    } status_t;

    // floor(word * 14 / 65535), using 65536 = 65535 + 1
    function automatic logic [SPEED_W-1:0] speed_of(input logic [WORD_W-1:0] word);
        logic [WORD_W+SPEED_W-1:0] prod;
        logic [SPEED_W-1:0]        quo;
        logic [WORD_W:0]           rem;
        prod = (WORD_W+SPEED_W)'(word) * (WORD_W+SPEED_W)'(SPEED_TOP);
        quo  = prod[WORD_W+SPEED_W-1:WORD_W];
        rem  = (WORD_W+1)'(prod[WORD_W-1:0]) + (WORD_W+1)'(quo);
        return quo + SPEED_W'(rem >= (WORD_W+1)'(WORD_FULL));
    endfunction

endpackage

FILE: src/framed_reply_receiver_with_sum_check_core.sv
// ----------------------------------------------------------------------------
// framed_reply_receiver_with_sum_check_core
// parses 7-byte reply frames and keeps the values they carry
// ----------------------------------------------------------------------------
// Input stream s_axis: one received byte per transfer in tdata.
// Output stream m_axis: one result per input byte; tuser carries the status
// (in progress, frame applied, checksum mismatch, stray byte, foreign frame),
// tdata carries every held value as it stands after that byte.
// A frame is start mark 0xFF, address, command high, command low, data high,
// data low and checksum; only frames for the address written on cfg_wr_data
// are checked and applied, others are consumed and dropped.
// Latency: the result of a byte is valid the cycle after its transfer.
// Throughput: one byte per cycle, set by the single result register; a new
// byte is taken in the same cycle as the previous result leaves.
// If the receiver stalls, the result holds and s_axis_tready drops until the
// result is taken.
// Reset: hunts for a start mark, peer address 0, held values 0, speed 5.
// ----------------------------------------------------------------------------
`include "framed_reply_receiver_with_sum_check_core_macros.svh"

module framed_reply_receiver_with_sum_check_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [frsc_pkg::BYTE_W-1:0] cfg_wr_data,  // peer_address
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [frsc_pkg::BYTE_W-1:0] s_axis_tdata,  // rx_byte
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // servo_one_angle, servo_two_angle, stepper_speed, steps_left,
    // stepper_turn, range_reading, target_x, target_y, 4 zero bits
    output logic [frsc_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic [frsc_pkg::STAT_W-1:0] m_axis_tuser   // status
);

    typedef enum logic [2:0] {
        POS_HUNT    = 3'd0,
        POS_ADDR    = 3'd1,
        POS_CMD_HI  = 3'd2,
        POS_CMD_LO  = 3'd3,
        POS_DATA_HI = 3'd4,
        POS_DATA_LO = 3'd5,
        POS_CHECK   = 3'd6
    } pos_t;

    localparam int unsigned BW = frsc_pkg::BYTE_W;
    localparam int unsigned WW = frsc_pkg::WORD_W;

    logic [BW-1:0]                peer_reg;
    pos_t                         pos_reg, pos_next;
    logic                         addressed_reg, addressed_next;
    logic [BW-1:0]                sum_reg, sum_next;
    logic [BW-1:0]                cmd_lo_reg, cmd_lo_next;
    logic [BW-1:0]                data_hi_reg, data_hi_next;
    logic [BW-1:0]                data_lo_reg, data_lo_next;
    logic [BW-1:0]                servo_one_reg, servo_one_next;
    logic [BW-1:0]                servo_two_reg, servo_two_next;
    logic [frsc_pkg::SPEED_W-1:0] speed_reg, speed_next;
    logic [WW-1:0]                steps_reg, steps_next;
    logic [BW-1:0]                turn_reg, turn_next;
    logic [BW-1:0]                range_reg, range_next;
    logic [WW-1:0]                target_x_reg, target_x_next;
    logic [WW-1:0]                target_y_reg, target_y_next;
    frsc_pkg::status_t            status_reg, status_next;
    logic                         m_valid_reg;
    logic                         s_fire;
    logic [BW-1:0]                rx;
    logic [WW-1:0]                word;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign word          = {data_hi_reg, data_lo_reg};

    always_comb begin
        pos_next       = pos_reg;
        addressed_next = addressed_reg;
        sum_next       = sum_reg;
        cmd_lo_next    = cmd_lo_reg;
        data_hi_next   = data_hi_reg;
        data_lo_next   = data_lo_reg;
        servo_one_next = servo_one_reg;
        servo_two_next = servo_two_reg;
        speed_next     = speed_reg;
        steps_next     = steps_reg;
        turn_next      = turn_reg;
        range_next     = range_reg;
        target_x_next  = target_x_reg;
        target_y_next  = target_y_reg;
        status_next    = frsc_pkg::ST_BUSY;
        unique case (pos_reg)
            POS_HUNT: begin
                if (rx == frsc_pkg::START_MARK) begin
                    pos_next = POS_ADDR;
                end else begin
                    status_next = frsc_pkg::ST_STRAY;
                end
            end
            POS_ADDR: begin
                addressed_next = (rx == peer_reg);
                pos_next       = POS_CMD_HI;
            end
            POS_CMD_HI: begin
                sum_next = rx;
                pos_next = POS_CMD_LO;
            end
            POS_CMD_LO: begin
                cmd_lo_next = rx;
                sum_next    = sum_reg + rx;
                pos_next    = POS_DATA_HI;
            end
            POS_DATA_HI: begin
                data_hi_next = rx;
                sum_next     = sum_reg + rx;
                pos_next     = POS_DATA_LO;
            end
            POS_DATA_LO: begin
                data_lo_next = rx;
                sum_next     = sum_reg + rx;
                pos_next     = POS_CHECK;
            end
            POS_CHECK: begin
                pos_next       = POS_HUNT;
                addressed_next = 1'b0;
                if (!addressed_reg) begin
                    status_next = frsc_pkg::ST_FOREIGN;
                end else if (BW'(sum_reg + peer_reg) != rx) begin
                    status_next = frsc_pkg::ST_BAD_SUM;
                end else begin
                    status_next = frsc_pkg::ST_APPLIED;
                    case (cmd_lo_reg)
                        frsc_pkg::CMD_SERVO_ONE: servo_one_next = data_lo_reg;
                        frsc_pkg::CMD_SERVO_TWO: servo_two_next = data_lo_reg;
                        frsc_pkg::CMD_SPEED:     speed_next = frsc_pkg::speed_of(word);
                        frsc_pkg::CMD_STEPS:     steps_next = word;
                        frsc_pkg::CMD_TURN:      turn_next = data_lo_reg;
                        frsc_pkg::CMD_RANGE:     range_next = data_lo_reg;
                        frsc_pkg::CMD_TARGET_X:  target_x_next = word;
                        frsc_pkg::CMD_TARGET_Y:  target_y_next = word;
                        default: ;
                    endcase
                end
            end
            default: begin
                pos_next       = POS_HUNT;
                addressed_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            peer_reg      <= '0;
            pos_reg       <= POS_HUNT;
            addressed_reg <= 1'b0;
            servo_one_reg <= '0;
            servo_two_reg <= '0;
            speed_reg     <= frsc_pkg::SPEED_RESET;
            steps_reg     <= '0;
            turn_reg      <= '0;
            range_reg     <= '0;
            target_x_reg  <= '0;
            target_y_reg  <= '0;
            status_reg    <= frsc_pkg::ST_BUSY;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                peer_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                pos_reg       <= pos_next;
                addressed_reg <= addressed_next;
                servo_one_reg <= servo_one_next;
                servo_two_reg <= servo_two_next;
                speed_reg     <= speed_next;
                steps_reg     <= steps_next;
                turn_reg      <= turn_next;
                range_reg     <= range_next;
                target_x_reg  <= target_x_next;
                target_y_reg  <= target_y_next;
                status_reg    <= status_next;
                m_valid_reg   <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    // frame capture, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sum_reg     <= sum_next;
            cmd_lo_reg  <= cmd_lo_next;
            data_hi_reg <= data_hi_next;
            data_lo_reg <= data_lo_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {4'b0000, target_y_reg, target_x_reg, range_reg, turn_reg,
                            steps_reg, speed_reg, servo_two_reg, servo_one_reg};

    `FRSC_ASSERT_SAME(a_fire_needs_room, s_fire, !m_valid_reg || m_axis_tready,
        "transfer accepted while result is stalled")
    `FRSC_ASSERT_NEXT(a_done_returns_hunt, s_fire && status_next != frsc_pkg::ST_BUSY,
        pos_reg == POS_HUNT, "frame end did not return to hunting")
    `FRSC_ASSERT_HOLD(a_addr_in_frame,
        !addressed_reg || (pos_reg != POS_HUNT && pos_reg != POS_ADDR),
        "addressed flag set outside a frame")
    `FRSC_ASSERT_SAME(a_held_only_on_apply, !$stable(m_axis_tdata),
        m_axis_tuser == frsc_pkg::ST_APPLIED, "held value changed without an applied frame")

endmodule
